/* src/fiet_pkg.sv */
// Shared types, constants and seed table of the find-or-insert entry table.
`default_nettype none

package fiet_pkg;

    // Default configuration
    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int ADDRESS_BYTES_DEF = 8;

    // Seeded primitive entries occupy handles 0 up to SEED_COUNT-1
    localparam int SEED_COUNT = 10;

    // Element handle that means "no type"
    localparam logic [8:0] NONE_HANDLE = 9'd256;

    // Kind codes of the seeded entries
    localparam logic [3:0] KIND_NULL   = 4'd0;
    localparam logic [3:0] KIND_WORD   = 4'd1;
    localparam logic [3:0] KIND_INT    = 4'd2;
    localparam logic [3:0] KIND_CHAR   = 4'd3;
    localparam logic [3:0] KIND_BYTE   = 4'd4;
    localparam logic [3:0] KIND_LONG   = 4'd5;
    localparam logic [3:0] KIND_FLOAT  = 4'd6;
    localparam logic [3:0] KIND_DOUBLE = 4'd7;
    localparam logic [3:0] KIND_BOOL   = 4'd8;
    localparam logic [3:0] KIND_STRING = 4'd9;

    // One stored entry
    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  size;
        logic [8:0]  elem;
        logic [31:0] count;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic fin_hit;
        logic fin_add;
        logic fin_full;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
        logic exhausted;
        logic full;
    } status_t;

    // Build the seeded entry held at a given handle
    function automatic entry_t seed_entry(input logic [3:0] idx, input logic [3:0] addr_bytes);
        entry_t e;
        e.elem  = NONE_HANDLE;
        e.count = 32'd0;
        case (idx)
            4'd0:
            begin
                e.kind = KIND_NULL;   e.size = 4'd0;
            end
            4'd1:
            begin
                e.kind = KIND_WORD;   e.size = addr_bytes;
            end
            4'd2:
            begin
                e.kind = KIND_INT;    e.size = 4'd4;
            end
            4'd3:
            begin
                e.kind = KIND_CHAR;   e.size = 4'd1;
            end
            4'd4:
            begin
                e.kind = KIND_BYTE;   e.size = 4'd1;
            end
            4'd5:
            begin
                e.kind = KIND_LONG;   e.size = 4'd8;
            end
            4'd6:
            begin
                e.kind = KIND_FLOAT;  e.size = 4'd4;
            end
            4'd7:
            begin
                e.kind = KIND_DOUBLE; e.size = 4'd8;
            end
            4'd8:
            begin
                e.kind = KIND_BOOL;   e.size = 4'd1;
            end
            4'd9:
            begin
                e.kind = KIND_STRING; e.size = addr_bytes; e.elem = 9'd3;
            end
            default:
            begin
                e.kind = KIND_NULL;   e.size = 4'd0;
            end
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

/* src/fiet_dpath.sv */
// Datapath of the entry table: request register, entry memory, scan and compare, result.
`default_nettype none

module fiet_dpath #(
    parameter int TABLE_DEPTH   = fiet_pkg::TABLE_DEPTH_DEF,
    parameter int ADDRESS_BYTES = fiet_pkg::ADDRESS_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fiet_pkg::cmd_t   cmd,
    output fiet_pkg::status_t     status,
    input  wire logic [3:0]       type_code,
    input  wire logic [3:0]       byte_size,
    input  wire logic [8:0]       element,
    input  wire logic [31:0]      elem_count,
    output logic [7:0]            handle,
    output logic                  was_added,
    output logic                  table_full
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] SEED_C  = CW'(fiet_pkg::SEED_COUNT);
    localparam logic [IW-1:0] SEED_I  = IW'(fiet_pkg::SEED_COUNT);
    localparam logic [3:0]    ABYTES  = 4'(ADDRESS_BYTES);

    fiet_pkg::entry_t mem [TABLE_DEPTH];

    fiet_pkg::entry_t req_reg;
    fiet_pkg::entry_t rd_data_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic [CW-1:0]    cnt_reg,    cnt_next;
    logic [CW-1:0]    scan_reg,   scan_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [7:0]       handle_reg;
    logic             added_reg;
    logic             full_reg;

    logic             rd_issue;
    fiet_pkg::entry_t rd_entry;

    // Issue a read while entries remain below the fill count
    assign rd_issue = cmd.scan && (scan_reg < cnt_reg);

    // Serve seeded handles from the constant table, the rest from memory
    always_comb
    begin
        if (rd_idx_reg < SEED_I)
            rd_entry = fiet_pkg::seed_entry(rd_idx_reg[3:0], ABYTES);
        else
            rd_entry = rd_data_reg;
    end

    // Status towards the controller
    assign status.hit       = rd_vld_reg && (rd_entry == req_reg);
    assign status.exhausted = !rd_vld_reg && (scan_reg >= cnt_reg);
    assign status.full      = (cnt_reg == DEPTH_C);

    // Next values of the scan and fill control
    always_comb
    begin
        cnt_next    = cnt_reg;
        scan_next   = scan_reg;
        rd_vld_next = 1'b0;
        if (cmd.load)
        begin
            scan_next = '0;
        end
        else if (cmd.scan)
        begin
            rd_vld_next = rd_issue;
            if (rd_issue)
                scan_next = scan_reg + CW'(1);
        end
        if (cmd.fin_add)
            cnt_next = cnt_reg + CW'(1);
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= SEED_C;
            scan_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            scan_reg   <= scan_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Capture request, read and write memory, hold result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg.kind  <= type_code;
            req_reg.size  <= byte_size;
            req_reg.elem  <= element;
            req_reg.count <= elem_count;
        end
        if (rd_issue)
        begin
            rd_data_reg <= mem[scan_reg[IW-1:0]];
            rd_idx_reg  <= scan_reg[IW-1:0];
        end
        if (cmd.fin_add)
            mem[cnt_reg[IW-1:0]] <= req_reg;
        if (cmd.fin_hit)
        begin
            handle_reg <= 8'(rd_idx_reg);
            added_reg  <= 1'b0;
            full_reg   <= 1'b0;
        end
        else if (cmd.fin_add)
        begin
            handle_reg <= 8'(cnt_reg);
            added_reg  <= 1'b1;
            full_reg   <= 1'b0;
        end
        else if (cmd.fin_full)
        begin
            handle_reg <= 8'd0;
            added_reg  <= 1'b0;
            full_reg   <= 1'b1;
        end
    end

    assign handle     = handle_reg;
    assign was_added  = added_reg;
    assign table_full = full_reg;

    // Fill count stays between the seed count and the depth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg >= SEED_C) && (cnt_reg <= DEPTH_C))
        else $error("fill count out of range");

    // An append advances the fill count by one
    a_add_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_add |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("append did not advance fill count");

    // Full is reported only with every slot taken and no append alongside
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_full |-> (status.full && !cmd.fin_add))
        else $error("full reported with a free slot");

endmodule

`default_nettype wire

/* src/fiet_ctrl.sv */
// Controller state machine of the entry table: accept, scan, finish.
`default_nettype none

module fiet_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output fiet_pkg::cmd_t         cmd,
    input  wire fiet_pkg::status_t status
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg,  done_next;

    // Decode commands from the state and status
    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.scan     = 1'b0;
        cmd.fin_hit  = 1'b0;
        cmd.fin_add  = 1'b0;
        cmd.fin_full = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit)
                begin
                    cmd.fin_hit = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (status.exhausted)
                begin
                    cmd.fin_full = status.full;
                    cmd.fin_add  = !status.full;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = cmd.fin_hit || cmd.fin_add || cmd.fin_full;
    end

    // Hold state and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // The result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // A match ends the scan with a result next cycle
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.hit) |=> (done_reg && !busy))
        else $error("match did not produce a result");

    // At most one finish command at a time
    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.fin_hit, cmd.fin_add, cmd.fin_full}))
        else $error("conflicting finish commands");

endmodule

`default_nettype wire

/* src/find_or_insert_entry_table_core.sv */
// Top level of the find-or-insert entry table: controller and datapath.
// An accepted request is loaded into the request register; the scan then reads one entry per
// cycle from handle 0 and compares each registered read, ending on a match at handle i or on a
// miss over all n stored entries (at most TABLE_DEPTH). No request is accepted during the scan;
// the next may be accepted in the result cycle, so the spacing is set by the scan of the memory.
// Reset: ten seeded entries are present at once (served from a constant table); no clearing pass.
// Results are strobed by done for one cycle; the receiver cannot stall.
`default_nettype none

module find_or_insert_entry_table_core #(
    parameter int TABLE_DEPTH   = fiet_pkg::TABLE_DEPTH_DEF,
    parameter int ADDRESS_BYTES = fiet_pkg::ADDRESS_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  type_code,
    input  wire logic [3:0]  byte_size,
    input  wire logic [8:0]  element,
    input  wire logic [31:0] elem_count,
    output logic             done,
    output logic [7:0]       handle,
    output logic             was_added,
    output logic             table_full
);

    fiet_pkg::cmd_t    cmd;
    fiet_pkg::status_t status;

    fiet_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    fiet_dpath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .type_code  (type_code),
        .byte_size  (byte_size),
        .element    (element),
        .elem_count (elem_count),
        .handle     (handle),
        .was_added  (was_added),
        .table_full (table_full)
    );

endmodule

`default_nettype wire

/* test/tb_find_or_insert_entry_table_core.sv */
// Testbench for the find-or-insert entry table: queued requests, shadow table check.
`timescale 1ns / 100ps

module tb_find_or_insert_entry_table_core;

    localparam int TABLE_DEPTH   = 256;
    localparam int ADDRESS_BYTES = 8;
    localparam int RANDOM_COUNT  = 1650;
    localparam int CALM_TAIL     = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_PRINTED   = 30;

    // Kinds beyond the seeded primitives
    localparam logic [3:0] KIND_POINTER  = 4'd10;
    localparam logic [3:0] KIND_VECTOR   = 4'd11;
    localparam logic [3:0] KIND_FUNCTION = 4'd12;

    typedef struct {
        fiet_pkg::entry_t ent;
        int               gap;
        bit               drain;
    } request_t;

    typedef struct {
        logic [7:0] handle;
        logic       added;
        logic       full;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [3:0]  type_code = '0;
    logic [3:0]  byte_size = '0;
    logic [8:0]  element = '0;
    logic [31:0] elem_count = '0;
    logic        busy;
    logic        done;
    logic [7:0]  handle;
    logic        was_added;
    logic        table_full;

    request_t         pending_requests[$];
    fiet_pkg::entry_t known_entries[$];
    reply_t           expected_replies[$];
    fiet_pkg::entry_t shadow_entries[TABLE_DEPTH];
    int               shadow_used;

    request_t next_req;
    bit       next_loaded = 1'b0;
    int       gap_left = 0;
    int       in_flight = 0;
    int       mismatches = 0;
    int       n_found = 0;
    int       n_appended = 0;
    int       n_refused = 0;
    int       quiet_cycles = 0;

    find_or_insert_entry_table_core #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .type_code  (type_code),
        .byte_size  (byte_size),
        .element    (element),
        .elem_count (elem_count),
        .done       (done),
        .handle     (handle),
        .was_added  (was_added),
        .table_full (table_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Primitive entry held at handle k after reset; its kind code equals k
    function automatic fiet_pkg::entry_t primitive_entry(int k);
        fiet_pkg::entry_t e;
        e.kind  = 4'(k);
        e.elem  = fiet_pkg::NONE_HANDLE;
        e.count = 32'd0;
        case (k)
            1, 9:    e.size = 4'(ADDRESS_BYTES);
            2, 6:    e.size = 4'd4;
            3, 4, 8: e.size = 4'd1;
            5, 7:    e.size = 4'd8;
            default: e.size = 4'd0;
        endcase
        // a string is a pointer to char
        if (k == 9)
            e.elem = {1'b0, 4'd0, fiet_pkg::KIND_CHAR};
        return e;
    endfunction

    // Look the entry up in the shadow table, appending it on a miss if room remains
    function automatic reply_t intern_entry(fiet_pkg::entry_t e);
        reply_t r;
        r.handle = 8'd0;
        r.added  = 1'b0;
        r.full   = 1'b0;
        for (int i = 0; i < shadow_used; i++)
        begin
            if (shadow_entries[i] == e)
            begin
                r.handle = 8'(i);
                return r;
            end
        end
        if (shadow_used >= TABLE_DEPTH)
        begin
            r.full = 1'b1;
            return r;
        end
        shadow_entries[shadow_used] = e;
        r.handle = 8'(shadow_used);
        r.added  = 1'b1;
        shadow_used++;
        return r;
    endfunction

    function automatic fiet_pkg::entry_t random_entry();
        fiet_pkg::entry_t e;
        e.kind = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 12))
                                            : 4'($urandom_range(13, 15));
        e.size = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 8))
                                            : 4'($urandom_range(9, 15));
        case ($urandom_range(0, 3))
            0:       e.elem = fiet_pkg::NONE_HANDLE;
            1:       e.elem = 9'($urandom_range(0, 255));
            2:       e.elem = 9'($urandom_range(257, 511));
            default: e.elem = 9'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       e.count = 32'd0;
            1:       e.count = $urandom_range(0, 64);
            2:       e.count = 32'hFFFF_FFFF - $urandom_range(0, 64);
            default: e.count = $urandom;
        endcase
        return e;
    endfunction

    task automatic queue_request(fiet_pkg::entry_t e, int gap, bit drain);
        request_t q;
        q.ent   = e;
        q.gap   = gap;
        q.drain = drain;
        pending_requests.insert(pending_requests.size(), q);
        known_entries.insert(known_entries.size(), e);
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Drive requests: honour idle bursts and drain markers, hold start until taken
    always @(posedge clk)
    begin : drive_requests
        logic took;
        logic start_nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
            in_flight = 0;
        end
        else
        begin
            took = start && !busy;
            if (took)
                in_flight++;
            if (done)
                in_flight--;
            start_nxt = start && !took;
            if (!start_nxt)
            begin
                if (!next_loaded && pending_requests.size() != 0)
                begin
                    next_req = pending_requests.pop_front();
                    gap_left = next_req.gap;
                    next_loaded = 1'b1;
                end
                if (next_loaded)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    else if (!(next_req.drain && in_flight != 0))
                    begin
                        type_code  <= next_req.ent.kind;
                        byte_size  <= next_req.ent.size;
                        element    <= next_req.ent.elem;
                        elem_count <= next_req.ent.count;
                        next_loaded = 1'b0;
                        start_nxt = 1'b1;
                    end
                end
            end
            start <= start_nxt;
        end
    end

    // Check each strobed result against the oldest expectation, then predict new requests
    always @(posedge clk)
    begin : check_replies
        reply_t           want;
        fiet_pkg::entry_t taken;
        if (!rst_n)
        begin
            for (int k = 0; k < fiet_pkg::SEED_COUNT; k++)
                shadow_entries[k] = primitive_entry(k);
            shadow_used = fiet_pkg::SEED_COUNT;
        end
        else
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch($sformatf("result handle %0d with no request outstanding",
                                              handle));
                else
                begin
                    want = expected_replies.pop_front();
                    if (handle !== want.handle)
                        report_mismatch($sformatf("handle %0d, expected %0d",
                                                  handle, want.handle));
                    if (was_added !== want.added)
                        report_mismatch($sformatf("was_added %b, expected %b (handle %0d)",
                                                  was_added, want.added, want.handle));
                    if (table_full !== want.full)
                        report_mismatch($sformatf("table_full %b, expected %b (handle %0d)",
                                                  table_full, want.full, want.handle));
                    if (want.full)
                        n_refused++;
                    else if (want.added)
                        n_appended++;
                    else
                        n_found++;
                end
            end
            if (start && !busy)
            begin
                taken.kind  = type_code;
                taken.size  = byte_size;
                taken.elem  = element;
                taken.count = elem_count;
                expected_replies.insert(expected_replies.size(), intern_entry(taken));
            end
        end
    end

    // Watchdog: end the run when no request or result moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : run_test
        fiet_pkg::entry_t e;
        int               mode;
        int               gap;
        int               pick;

        // Directed: every seed, out-of-range codes, near misses of seeds and repeats
        for (int k = 0; k < fiet_pkg::SEED_COUNT; k++)
            queue_request(primitive_entry(k), 0, 1'b0);
        queue_request('{kind: fiet_pkg::KIND_STRING, size: 4'd8,
                        elem: fiet_pkg::NONE_HANDLE, count: 32'd0}, 0, 1'b0);
        queue_request('{kind: fiet_pkg::KIND_STRING, size: 4'd8,
                        elem: fiet_pkg::NONE_HANDLE, count: 32'd0}, 3, 1'b0);
        queue_request('{kind: 4'hF, size: 4'hF, elem: 9'h1FF, count: 32'hFFFF_FFFF}, 0, 1'b0);
        queue_request('{kind: fiet_pkg::KIND_NULL, size: 4'd0, elem: 9'd0, count: 32'd0},
                      0, 1'b0);
        queue_request('{kind: KIND_POINTER, size: 4'd8, elem: 9'd3, count: 32'd0}, 0, 1'b0);
        queue_request('{kind: KIND_VECTOR, size: 4'd4, elem: 9'd2, count: 32'd16}, 1, 1'b0);
        queue_request('{kind: KIND_VECTOR, size: 4'd4, elem: 9'd2, count: 32'd16}, 0, 1'b0);
        queue_request('{kind: KIND_FUNCTION, size: 4'd8, elem: fiet_pkg::NONE_HANDLE,
                        count: 32'h8000_0000}, 0, 1'b0);
        queue_request('{kind: fiet_pkg::KIND_WORD, size: 4'd4,
                        elem: fiet_pkg::NONE_HANDLE, count: 32'd0}, 0, 1'b0);
        queue_request('{kind: fiet_pkg::KIND_INT, size: 4'd4,
                        elem: fiet_pkg::NONE_HANDLE, count: 32'd1}, 0, 1'b0);
        queue_request('{kind: 4'd13, size: 4'd9, elem: 9'd257, count: 32'h5555_5555}, 0, 1'b0);
        queue_request('{kind: 4'd14, size: 4'd0, elem: 9'd0, count: 32'hAAAA_AAAA}, 0, 1'b0);
        // hold until the table has answered everything before repeating
        queue_request('{kind: 4'hF, size: 4'hF, elem: 9'h1FF, count: 32'hFFFF_FFFF}, 0, 1'b1);

        // Random: repeats, one-bit near misses, seeds and fresh entries; fills the table
        mode = 0;
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n % 50 == 0)
                mode = $urandom_range(0, 2);
            if (n >= RANDOM_COUNT - CALM_TAIL)
                mode = 0;
            gap = 0;
            if (mode == 1 && $urandom_range(0, 99) < 20)
                gap = $urandom_range(1, 18);
            else if (mode == 2 && $urandom_range(0, 99) < 60)
                gap = $urandom_range(1, 18);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                e = known_entries[$urandom_range(0, known_entries.size() - 1)];
            else if (pick < 60)
                e = known_entries[$urandom_range(0, known_entries.size() - 1)]
                    ^ (49'd1 << $urandom_range(0, 48));
            else if (pick < 68)
                e = primitive_entry($urandom_range(0, fiet_pkg::SEED_COUNT - 1));
            else
                e = random_entry();
            queue_request(e, gap,
                          (n < RANDOM_COUNT - CALM_TAIL) && ($urandom_range(0, 99) == 0));
        end

        // Release reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the queue to empty and every result to arrive, then let it settle
        @(negedge clk);
        while (pending_requests.size() != 0 || next_loaded || start
               || expected_replies.size() != 0)
            @(negedge clk);
        repeat (TABLE_DEPTH + 8) @(negedge clk);
        if (expected_replies.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));

        $display("Covered %0d requests: %0d found, %0d appended, %0d refused with the table full.",
                 n_found + n_appended + n_refused, n_found, n_appended, n_refused);
        $display("Shadow table ended with %0d of %0d entries; %0d mismatches.",
                 shadow_used, TABLE_DEPTH, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/fiet_pkg.sv
src/fiet_dpath.sv
src/fiet_ctrl.sv
src/find_or_insert_entry_table_core.sv
test/tb_find_or_insert_entry_table_core.sv
